/* hdl/ktdt_pkg.sv */
// Shared types and constants for the key tap, hold and double-tap classifier.
package ktdt_pkg;

    // Field and register widths
    localparam int unsigned TimeW  = 32;
    localparam int unsigned ThrW   = 16;
    localparam int unsigned StateW = 3;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = ThrW;
    localparam int unsigned OutTdataW = 8;

    // Key state codes
    typedef enum logic [StateW-1:0] {
        KS_RELEASED = 3'd0,
        KS_PRESSED  = 3'd1,
        KS_TAPPED   = 3'd2,
        KS_HELD     = 3'd3,
        KS_SINGLE   = 3'd4,
        KS_DOUBLE   = 3'd5
    } t_key_state;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_HOLD_TIME   = 3'd0,
        CFG_DT_WINDOW   = 3'd1,
        CFG_RELEASE     = 3'd2,
        CFG_MOD_TAP_EN  = 3'd3,
        CFG_DBL_TAP_EN  = 3'd4
    } t_cfg_idx;

    // Register values after reset
    localparam logic [ThrW-1:0] HoldTimeRst  = 16'd200;
    localparam logic [ThrW-1:0] DtWindowRst  = 16'd200;
    localparam logic [ThrW-1:0] ReleaseRst   = 16'd10;

endpackage

/* hdl/key_tap_hold_doubletap_fsm.sv */
// Key tap, hold and double-tap classifier: one key scan in, one key state out.
//
// Usage
//   Slave stream: one scan per request. s_axis_tuser carries the scan result
//   (1 key seen pressed, 0 released); s_axis_tdata carries the 32-bit
//   millisecond time, which may wrap.
//   Master stream: one result per scan, the new key state in m_axis_tdata.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 hold time, 1 double-tap window, 2 release time, 3 mod-tap enable,
//   4 double-tap enable); other indexes are ignored. Write only while idle.
// Timing
//   The accepting edge loads the input register; then, after one pass of
//   subtract, compare and state update, the result register is loaded and
//   m_axis_tvalid rises. Throughput is one scan per cycle while the receiver
//   does not stall the result register.
// Reset and stall
//   Reset returns the key to released, clears the change time and the armed
//   flag, and loads the default thresholds. When the receiver stalls, the
//   result register holds and both stages freeze; s_axis_tready drops only
//   once the input register is also occupied.
module key_tap_hold_doubletap_fsm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Scan requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ktdt_pkg::TimeW-1:0]        s_axis_tdata,  // [31:0] now_ms
    input  logic                              s_axis_tuser,  // [0] operation
    // Key state results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ktdt_pkg::OutTdataW-1:0]    m_axis_tdata,  // [2:0] key_state, rest zero
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [ktdt_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [ktdt_pkg::CfgDataW-1:0]     i_cfg_data
);
    import ktdt_pkg::*;

    // Configuration registers
    logic [ThrW-1:0] r_hold_time;
    logic [ThrW-1:0] r_dt_window;
    logic [ThrW-1:0] r_release_time;
    logic            r_mod_tap_en;
    logic            r_dbl_tap_en;

    // Input stage
    logic             r_in_valid;
    logic             r_in_op;
    logic [TimeW-1:0] r_in_now;

    // Key state
    t_key_state       r_state;
    t_key_state       n_state;
    logic [TimeW-1:0] r_last_change;
    logic [TimeW-1:0] n_last_change;
    logic             r_armed;
    logic             n_armed;

    // Result stage
    logic             r_out_valid;
    t_key_state       r_out_state;

    logic             advance;
    logic [TimeW-1:0] elapsed;
    logic             gt_hold;
    logic             gt_window;
    logic             gt_release;

    // Both stages move together unless a result waits untaken
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time    <= HoldTimeRst;
            r_dt_window    <= DtWindowRst;
            r_release_time <= ReleaseRst;
            r_mod_tap_en   <= 1'b0;
            r_dbl_tap_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_TIME:  r_hold_time    <= i_cfg_data;
                CFG_DT_WINDOW:  r_dt_window    <= i_cfg_data;
                CFG_RELEASE:    r_release_time <= i_cfg_data;
                CFG_MOD_TAP_EN: r_mod_tap_en   <= i_cfg_data[0];
                CFG_DBL_TAP_EN: r_dbl_tap_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture the scan request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op  <= s_axis_tuser;
            r_in_now <= s_axis_tdata;
        end
    end

    // Elapsed time since the last change, wrapping, and threshold compares
    assign elapsed    = r_in_now - r_last_change;
    assign gt_hold    = elapsed > {{(TimeW-ThrW){1'b0}}, r_hold_time};
    assign gt_window  = elapsed > {{(TimeW-ThrW){1'b0}}, r_dt_window};
    assign gt_release = elapsed > {{(TimeW-ThrW){1'b0}}, r_release_time};

    // Next key state for the held scan
    always_comb begin
        n_state       = r_state;
        n_last_change = r_last_change;
        n_armed       = r_armed;
        if (r_in_op) begin
            // Press scan
            if (r_state == KS_PRESSED && gt_hold && r_mod_tap_en) begin
                n_state       = KS_HELD;
                n_last_change = r_in_now;
            end else if (r_state == KS_RELEASED || r_state == KS_TAPPED) begin
                if (r_armed && r_dbl_tap_en) begin
                    n_state = KS_DOUBLE;
                    n_armed = 1'b0;
                end else begin
                    n_state = KS_PRESSED;
                    n_armed = 1'b1;
                end
                n_last_change = r_in_now;
            end
        end else begin
            // Release scan
            if (r_state == KS_PRESSED && r_mod_tap_en) begin
                n_state       = KS_TAPPED;
                n_last_change = r_in_now;
            end else if (gt_window && r_armed && r_dbl_tap_en) begin
                n_state       = KS_SINGLE;
                n_armed       = 1'b0;
                n_last_change = r_in_now;
            end else if (r_state != KS_RELEASED && gt_release) begin
                n_state       = KS_RELEASED;
                n_last_change = r_in_now;
            end
        end
    end

    // Commit the key state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= KS_RELEASED;
            r_last_change <= '0;
            r_armed       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state       <= n_state;
                r_last_change <= n_last_change;
                r_armed       <= n_armed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_state <= n_state;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutTdataW-StateW){1'b0}}, r_out_state};

endmodule
